### hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

    localparam int ADDR_W  = 7;
    localparam int REG_W   = 8;
    localparam int CNT_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int BIT_W   = 4;
    localparam int BIDX_W  = 6;
    localparam int POLL_W  = 8;

    localparam logic [POLL_W-1:0] ACK_TIMEOUT_RST = 8'd200;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] dev_addr;
        logic [REG_W-1:0]  reg_addr;
        logic [CNT_W-1:0]  byte_count;
        logic [BYTE_W-1:0] data_byte;
        logic              sda_in;
    } t_item;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic              done_res;
        logic              error;
        logic              busy_res;
    } t_result;

endpackage

### hw/rtl/i2cm_seq.sv
module i2cm_seq
    import i2cm_pkg::*;
#(
    parameter int MAX_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [POLL_W-1:0] i_cfg_wr_data,
    input  logic              i_step,
    input  t_item             i_item,
    output t_result           o_res
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int LW = $clog2(MAX_BYTES + 1);
    localparam int IW = (AW > BIDX_W) ? AW : BIDX_W;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_TX_LOW, PH_TX_HIGH,
        PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_POLL, PH_RX_LOW, PH_RX_HIGH,
        PH_RX_SAMPLE, PH_MACK_LOW, PH_MACK_HIGH, PH_MACK_END,
        PH_STOP_A, PH_STOP_B, PH_STOP_C
    } t_phase;

    t_phase             r_phase,   n_phase;
    logic [BIT_W-1:0]   r_bit_cnt, n_bit_cnt;
    logic [BIDX_W-1:0]  r_byte_idx, n_byte_idx;
    logic [BYTE_W-1:0]  r_shift,   n_shift;
    logic [LW-1:0]      r_load_idx, n_load_idx;
    logic               r_fail,    n_fail;
    logic [POLL_W-1:0]  r_poll,    n_poll;
    logic [ADDR_W-1:0]  r_addr,    n_addr;
    logic [REG_W-1:0]   r_reg,     n_reg;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic               r_is_read, n_is_read;
    logic [POLL_W-1:0]  r_ack_timeout;
    t_result            r_res,     n_res;

    logic [BYTE_W-1:0]  r_wbuf [MAX_BYTES];
    logic               buf_we;
    logic [AW-1:0]      buf_waddr;
    logic [BIDX_W-1:0]  buf_j;
    logic [IW-1:0]      buf_j_ext;
    logic [BYTE_W-1:0]  buf_rdata;
    logic               ack_done;
    logic               last_byte;
    logic [BYTE_W-1:0]  rx_shift;
    logic [BIT_W-1:0]   bit_inc;

    assign buf_waddr = AW'(r_load_idx);
    assign buf_j     = r_byte_idx - BIDX_W'(1);
    assign buf_j_ext = IW'(buf_j);
    assign buf_rdata = (32'(buf_j) < MAX_BYTES) ? r_wbuf[buf_j_ext[AW-1:0]] : '0;
    assign last_byte = r_byte_idx >= BIDX_W'(r_count);
    assign rx_shift  = {r_shift[BYTE_W-2:0], i_item.sda_in};
    assign bit_inc   = r_bit_cnt + BIT_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_bit_cnt  = r_bit_cnt;
        n_byte_idx = r_byte_idx;
        n_shift    = r_shift;
        n_load_idx = r_load_idx;
        n_fail     = r_fail;
        n_poll     = r_poll;
        n_addr     = r_addr;
        n_reg      = r_reg;
        n_count    = r_count;
        n_is_read  = r_is_read;
        buf_we     = 1'b0;
        ack_done   = 1'b0;
        n_res      = '0;
        n_res.scl_out = 1'b1;
        n_res.sda_out = 1'b1;

        // Requests are only honoured while the bus is idle.
        if (r_phase == PH_IDLE) begin
            if (i_item.req_type == REQ_LOAD) begin
                if (32'(r_load_idx) < MAX_BYTES) begin
                    buf_we     = 1'b1;
                    n_load_idx = r_load_idx + LW'(1);
                end
            end else if (i_item.req_type == REQ_WRITE || i_item.req_type == REQ_READ) begin
                n_addr     = i_item.dev_addr;
                n_reg      = i_item.reg_addr;
                n_count    = (32'(i_item.byte_count) > MAX_BYTES) ? CNT_W'(MAX_BYTES)
                                                                  : i_item.byte_count;
                n_is_read  = i_item.req_type == REQ_READ;
                n_fail     = 1'b0;
                n_load_idx = '0;
                n_byte_idx = '0;
                n_bit_cnt  = '0;
                n_poll     = '0;
                n_phase    = PH_START_A;
            end
        end

        case (n_phase)
            PH_IDLE: begin
            end
            PH_START_A: begin
                n_phase = PH_START_B;
            end
            PH_START_B: begin
                n_res.sda_out = 1'b0;
                n_shift   = {r_addr, (r_is_read && r_byte_idx == BIDX_W'(2))};
                n_bit_cnt = '0;
                n_phase   = PH_TX_LOW;
            end
            PH_TX_LOW: begin
                n_res.scl_out = 1'b0;
                n_res.sda_out = r_shift[BYTE_W-1];
                n_phase = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
                n_res.sda_out = r_shift[BYTE_W-1];
                n_shift   = {r_shift[BYTE_W-2:0], 1'b0};
                n_bit_cnt = bit_inc;
                n_phase   = (bit_inc >= BIT_W'(8)) ? PH_ACK_LOW : PH_TX_LOW;
            end
            PH_ACK_LOW: begin
                n_res.scl_out = 1'b0;
                n_poll  = '0;
                n_phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                n_phase = PH_ACK_POLL;
            end
            PH_ACK_POLL: begin
                if (!i_item.sda_in) begin
                    n_res.scl_out = 1'b0;
                    ack_done = 1'b1;
                end else if (r_poll >= r_ack_timeout) begin
                    n_fail = 1'b1;
                    n_res.scl_out = 1'b0;
                    ack_done = 1'b1;
                end else begin
                    n_poll = r_poll + POLL_W'(1);
                end
            end
            PH_RX_LOW: begin
                n_res.scl_out = 1'b0;
                n_phase = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
                n_phase = PH_RX_SAMPLE;
            end
            PH_RX_SAMPLE: begin
                n_res.scl_out = 1'b0;
                n_shift   = rx_shift;
                n_bit_cnt = bit_inc;
                if (bit_inc >= BIT_W'(8)) begin
                    n_res.read_byte  = rx_shift;
                    n_res.read_valid = 1'b1;
                    n_byte_idx = r_byte_idx + BIDX_W'(1);
                    n_phase    = PH_MACK_LOW;
                end else begin
                    n_phase = PH_RX_HIGH;
                end
            end
            PH_MACK_LOW: begin
                n_res.scl_out = 1'b0;
                n_res.sda_out = last_byte;
                n_phase = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
                n_res.sda_out = last_byte;
                n_phase = PH_MACK_END;
            end
            PH_MACK_END: begin
                n_res.scl_out = 1'b0;
                n_res.sda_out = last_byte;
                if (last_byte) begin
                    n_phase = PH_STOP_A;
                end else begin
                    n_bit_cnt = '0;
                    n_shift   = '0;
                    n_phase   = PH_RX_LOW;
                end
            end
            PH_STOP_A: begin
                n_res.scl_out = 1'b0;
                n_res.sda_out = 1'b0;
                n_phase = PH_STOP_B;
            end
            PH_STOP_B: begin
                n_res.sda_out = 1'b0;
                n_phase = PH_STOP_C;
            end
            PH_STOP_C: begin
                n_res.done_res = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // A finished acknowledge slot picks the next byte or bus condition.
        if (ack_done) begin
            if (!r_is_read) begin
                if (r_byte_idx < BIDX_W'(r_count) + BIDX_W'(1)) begin
                    n_byte_idx = r_byte_idx + BIDX_W'(1);
                    n_shift    = (r_byte_idx == '0) ? r_reg : buf_rdata;
                    n_bit_cnt  = '0;
                    n_phase    = PH_TX_LOW;
                end else begin
                    n_phase = PH_STOP_A;
                end
            end else if (r_byte_idx == '0) begin
                n_byte_idx = BIDX_W'(1);
                n_shift    = r_reg;
                n_bit_cnt  = '0;
                n_phase    = PH_TX_LOW;
            end else if (r_byte_idx == BIDX_W'(1)) begin
                n_byte_idx = BIDX_W'(2);
                n_phase    = PH_START_A;
            end else if (r_count == '0) begin
                n_phase = PH_STOP_A;
            end else begin
                n_byte_idx = '0;
                n_bit_cnt  = '0;
                n_shift    = '0;
                n_phase    = PH_RX_LOW;
            end
        end

        n_res.error    = n_fail;
        n_res.busy_res = n_phase != PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_cnt     <= '0;
            r_byte_idx    <= '0;
            r_shift       <= '0;
            r_load_idx    <= '0;
            r_fail        <= 1'b0;
            r_poll        <= '0;
            r_addr        <= '0;
            r_reg         <= '0;
            r_count       <= '0;
            r_is_read     <= 1'b0;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else begin
            if (i_cfg_wr_en) begin
                r_ack_timeout <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_phase    <= n_phase;
                r_bit_cnt  <= n_bit_cnt;
                r_byte_idx <= n_byte_idx;
                r_shift    <= n_shift;
                r_load_idx <= n_load_idx;
                r_fail     <= n_fail;
                r_poll     <= n_poll;
                r_addr     <= n_addr;
                r_reg      <= n_reg;
                r_count    <= n_count;
                r_is_read  <= n_is_read;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_res <= n_res;
            if (buf_we) begin
                r_wbuf[buf_waddr] <= i_item.data_byte;
            end
        end
    end

    assign o_res = r_res;

endmodule

### hw/rtl/i2c_register_master.sv
// I2C register master, stepped by one bus tick per input transaction.
// Input channel (i_in_valid / o_in_stall): each transaction carries a request
// code (tick, load a write byte, start write, start read), the start
// arguments, a byte for the write buffer and the sampled SDA level.
// Output channel (o_out_valid / i_out_stall): exactly one result per input
// transaction, with the SCL and SDA drive levels for the next half-bit, a
// received byte with its strobe, the stop strobe, the sticky error and busy.
// The ACK timeout register is written through i_cfg_wr_en / i_cfg_wr_data.
// A transaction lands in the input register, from which the sequencer runs
// once and loads the result register.
// Throughput is one transaction per cycle while the result is not stalled;
// the only loop is the sequencer step from its own state registers.
// A stalled result holds in the result register while one more transaction
// may wait in the input register; o_in_stall rises only when both are full.
// Reset leaves the sequencer idle, both registers empty and the timeout at
// 200 polls; the result register and the write buffer are left undefined.
module i2c_register_master
    import i2cm_pkg::*;
#(
    parameter int MAX_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [POLL_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [ADDR_W-1:0] i_dev_addr,
    input  logic [REG_W-1:0]  i_reg_addr,
    input  logic [CNT_W-1:0]  i_byte_count,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_sda_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_scl_out,
    output logic              o_sda_out,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic              o_read_valid,
    output logic              o_done_res,
    output logic              o_error,
    output logic              o_busy_res
);

    logic    r_in_valid;
    logic    r_out_valid;
    t_item   r_item;
    t_result res;
    logic    out_free;
    logic    step;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.req_type   <= i_req_type;
            r_item.dev_addr   <= i_dev_addr;
            r_item.reg_addr   <= i_reg_addr;
            r_item.byte_count <= i_byte_count;
            r_item.data_byte  <= i_data_byte;
            r_item.sda_in     <= i_sda_in;
        end
    end

    i2cm_seq #(
        .MAX_BYTES (MAX_BYTES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_item        (r_item),
        .o_res         (res)
    );

    assign o_out_valid  = r_out_valid;
    assign o_scl_out    = res.scl_out;
    assign o_sda_out    = res.sda_out;
    assign o_read_byte  = res.read_byte;
    assign o_read_valid = res.read_valid;
    assign o_done_res   = res.done_res;
    assign o_error      = res.error;
    assign o_busy_res   = res.busy_res;

endmodule
